// ===== sv/qcep_pkg.sv =====
`default_nettype none
package qcep_pkg;

  localparam int QW = 48;
  localparam int FRAC = 24;
  localparam int MAX_SEGMENTS_DEF = 64;

  localparam logic [3:0] OP_LDI  = 4'd0;
  localparam logic [3:0] OP_MOV  = 4'd1;
  localparam logic [3:0] OP_ADD  = 4'd2;
  localparam logic [3:0] OP_SUB  = 4'd3;
  localparam logic [3:0] OP_MUL  = 4'd4;
  localparam logic [3:0] OP_DIV  = 4'd5;
  localparam logic [3:0] OP_IDIV = 4'd6;
  localparam logic [3:0] OP_BZ   = 4'd7;
  localparam logic [3:0] OP_BNZ  = 4'd8;
  localparam logic [3:0] OP_JMP  = 4'd9;
  localparam logic [3:0] OP_EMIT = 4'd10;
  localparam logic [3:0] OP_FAIL = 4'd11;

  localparam logic [1:0] AM_MUL  = 2'd0;
  localparam logic [1:0] AM_QDIV = 2'd1;
  localparam logic [1:0] AM_IDIV = 2'd2;

  localparam logic [4:0] R_SX = 5'd0;
  localparam logic [4:0] R_SY = 5'd1;
  localparam logic [4:0] R_EX = 5'd2;
  localparam logic [4:0] R_EY = 5'd3;
  localparam logic [4:0] R_CX = 5'd4;
  localparam logic [4:0] R_CY = 5'd5;
  localparam logic [4:0] R_DX1 = 5'd6;
  localparam logic [4:0] R_DY1 = 5'd7;
  localparam logic [4:0] R_DX2 = 5'd8;
  localparam logic [4:0] R_DY2 = 5'd9;
  localparam logic [4:0] R_M1 = 5'd10;
  localparam logic [4:0] R_B1 = 5'd11;
  localparam logic [4:0] R_M2 = 5'd12;
  localparam logic [4:0] R_B2 = 5'd13;
  localparam logic [4:0] R_U = 5'd14;
  localparam logic [4:0] R_UY = 5'd15;
  localparam logic [4:0] R_V = 5'd16;
  localparam logic [4:0] R_VY = 5'd17;
  localparam logic [4:0] R_A0 = 5'd18;
  localparam logic [4:0] R_A1 = 5'd19;
  localparam logic [4:0] R_A2 = 5'd20;
  localparam logic [4:0] R_A3 = 5'd21;
  localparam logic [4:0] R_C0 = 5'd22;
  localparam logic [4:0] R_C1 = 5'd23;
  localparam logic [4:0] R_C2 = 5'd24;
  localparam logic [4:0] R_C3 = 5'd25;
  localparam logic [4:0] R_T = 5'd26;
  localparam logic [4:0] R_T2 = 5'd27;
  localparam logic [4:0] R_MA = 5'd28;
  localparam logic [4:0] R_BA = 5'd29;
  localparam logic [4:0] R_X = 5'd30;

  localparam logic [6:0] L_SKIP1 = 7'd20;
  localparam logic [6:0] L_SKIP2 = 7'd26;
  localparam logic [6:0] L_LOOP = 7'd30;
  localparam logic [6:0] L_LEG1V = 7'd40;
  localparam logic [6:0] L_LEG1D = 7'd42;
  localparam logic [6:0] L_LEG2V = 7'd48;
  localparam logic [6:0] L_LEG2D = 7'd50;
  localparam logic [6:0] L_MB = 7'd64;
  localparam logic [6:0] L_MG = 7'd74;
  localparam logic [6:0] L_FIN = 7'd90;
  localparam logic [6:0] L_FAIL = 7'd93;
  localparam logic [6:0] L_NONE = 7'd0;

  typedef struct packed {
    logic [3:0] op;
    logic [4:0] d;
    logic [4:0] a;
    logic [4:0] b;
    logic [6:0] tgt;
  } ins_t;

  typedef struct packed {
    logic       start;
    logic [1:0] mode;
  } arith_req_t;

  function automatic ins_t rom(input logic [6:0] pc);
    ins_t r;
    case (pc)
      7'd0:  r = '{OP_LDI, R_SX, 5'd0, R_SX, L_NONE};
      7'd1:  r = '{OP_LDI, R_SY, 5'd1, R_SX, L_NONE};
      7'd2:  r = '{OP_LDI, R_EX, 5'd2, R_SX, L_NONE};
      7'd3:  r = '{OP_LDI, R_EY, 5'd3, R_SX, L_NONE};
      7'd4:  r = '{OP_LDI, R_CX, 5'd4, R_SX, L_NONE};
      7'd5:  r = '{OP_LDI, R_CY, 5'd5, R_SX, L_NONE};
      7'd6:  r = '{OP_SUB, R_T, R_CX, R_SX, L_NONE};
      7'd7:  r = '{OP_IDIV, R_DX1, R_T, R_T, L_NONE};
      7'd8:  r = '{OP_SUB, R_T, R_EX, R_CX, L_NONE};
      7'd9:  r = '{OP_IDIV, R_DX2, R_T, R_T, L_NONE};
      7'd10: r = '{OP_SUB, R_T, R_CY, R_SY, L_NONE};
      7'd11: r = '{OP_IDIV, R_DY1, R_T, R_T, L_NONE};
      7'd12: r = '{OP_SUB, R_T, R_EY, R_CY, L_NONE};
      7'd13: r = '{OP_IDIV, R_DY2, R_T, R_T, L_NONE};
      7'd14: r = '{OP_BZ, R_T, R_DX1, R_DX1, L_SKIP1};
      7'd15: r = '{OP_SUB, R_T, R_SX, R_CX, L_NONE};
      7'd16: r = '{OP_SUB, R_T2, R_SY, R_CY, L_NONE};
      7'd17: r = '{OP_DIV, R_M1, R_T2, R_T, L_NONE};
      7'd18: r = '{OP_MUL, R_T, R_M1, R_SX, L_NONE};
      7'd19: r = '{OP_SUB, R_B1, R_SY, R_T, L_NONE};
      7'd20: r = '{OP_BZ, R_T, R_DX2, R_DX2, L_SKIP2};
      7'd21: r = '{OP_SUB, R_T, R_CX, R_EX, L_NONE};
      7'd22: r = '{OP_SUB, R_T2, R_CY, R_EY, L_NONE};
      7'd23: r = '{OP_DIV, R_M2, R_T2, R_T, L_NONE};
      7'd24: r = '{OP_MUL, R_T, R_M2, R_CX, L_NONE};
      7'd25: r = '{OP_SUB, R_B2, R_CY, R_T, L_NONE};
      7'd26: r = '{OP_MOV, R_U, R_SX, R_SX, L_NONE};
      7'd27: r = '{OP_MOV, R_UY, R_SY, R_SY, L_NONE};
      7'd28: r = '{OP_ADD, R_V, R_CX, R_DX2, L_NONE};
      7'd29: r = '{OP_ADD, R_VY, R_CY, R_DY2, L_NONE};
      7'd30: r = '{OP_MOV, R_A0, R_U, R_U, L_NONE};
      7'd31: r = '{OP_ADD, R_C0, R_U, R_DX1, L_NONE};
      7'd32: r = '{OP_MOV, R_A2, R_V, R_V, L_NONE};
      7'd33: r = '{OP_ADD, R_C2, R_V, R_DX2, L_NONE};
      7'd34: r = '{OP_BZ, R_T, R_DX1, R_DX1, L_LEG1V};
      7'd35: r = '{OP_MUL, R_T, R_M1, R_A0, L_NONE};
      7'd36: r = '{OP_ADD, R_A1, R_T, R_B1, L_NONE};
      7'd37: r = '{OP_MUL, R_T, R_M1, R_C0, L_NONE};
      7'd38: r = '{OP_ADD, R_C1, R_T, R_B1, L_NONE};
      7'd39: r = '{OP_JMP, R_T, R_T, R_T, L_LEG1D};
      7'd40: r = '{OP_MOV, R_A1, R_UY, R_UY, L_NONE};
      7'd41: r = '{OP_ADD, R_C1, R_UY, R_DY1, L_NONE};
      7'd42: r = '{OP_BZ, R_T, R_DX2, R_DX2, L_LEG2V};
      7'd43: r = '{OP_MUL, R_T, R_M2, R_A2, L_NONE};
      7'd44: r = '{OP_ADD, R_A3, R_T, R_B2, L_NONE};
      7'd45: r = '{OP_MUL, R_T, R_M2, R_C2, L_NONE};
      7'd46: r = '{OP_ADD, R_C3, R_T, R_B2, L_NONE};
      7'd47: r = '{OP_JMP, R_T, R_T, R_T, L_LEG2D};
      7'd48: r = '{OP_MOV, R_A3, R_VY, R_VY, L_NONE};
      7'd49: r = '{OP_ADD, R_C3, R_VY, R_DY2, L_NONE};
      7'd50: r = '{OP_ADD, R_U, R_U, R_DX1, L_NONE};
      7'd51: r = '{OP_ADD, R_UY, R_UY, R_DY1, L_NONE};
      7'd52: r = '{OP_ADD, R_V, R_V, R_DX2, L_NONE};
      7'd53: r = '{OP_ADD, R_VY, R_VY, R_DY2, L_NONE};
      7'd54: r = '{OP_SUB, R_T, R_A2, R_A0, L_NONE};
      7'd55: r = '{OP_BNZ, R_T, R_T, R_T, L_MB};
      7'd56: r = '{OP_MOV, R_X, R_A0, R_A0, L_NONE};
      7'd57: r = '{OP_SUB, R_T, R_C0, R_C2, L_NONE};
      7'd58: r = '{OP_BZ, R_T, R_T, R_T, L_FAIL};
      7'd59: r = '{OP_SUB, R_T2, R_C1, R_C3, L_NONE};
      7'd60: r = '{OP_DIV, R_MA, R_T2, R_T, L_NONE};
      7'd61: r = '{OP_MUL, R_T, R_MA, R_C0, L_NONE};
      7'd62: r = '{OP_SUB, R_BA, R_C1, R_T, L_NONE};
      7'd63: r = '{OP_JMP, R_T, R_T, R_T, L_FIN};
      7'd64: r = '{OP_SUB, R_T, R_C2, R_C0, L_NONE};
      7'd65: r = '{OP_BNZ, R_T, R_T, R_T, L_MG};
      7'd66: r = '{OP_MOV, R_X, R_C0, R_C0, L_NONE};
      7'd67: r = '{OP_SUB, R_T, R_A0, R_A2, L_NONE};
      7'd68: r = '{OP_BZ, R_T, R_T, R_T, L_FAIL};
      7'd69: r = '{OP_SUB, R_T2, R_A1, R_A3, L_NONE};
      7'd70: r = '{OP_DIV, R_MA, R_T2, R_T, L_NONE};
      7'd71: r = '{OP_MUL, R_T, R_MA, R_A0, L_NONE};
      7'd72: r = '{OP_SUB, R_BA, R_A1, R_T, L_NONE};
      7'd73: r = '{OP_JMP, R_T, R_T, R_T, L_FIN};
      7'd74: r = '{OP_SUB, R_T, R_A0, R_A2, L_NONE};
      7'd75: r = '{OP_BZ, R_T, R_T, R_T, L_FAIL};
      7'd76: r = '{OP_SUB, R_T2, R_A1, R_A3, L_NONE};
      7'd77: r = '{OP_DIV, R_MA, R_T2, R_T, L_NONE};
      7'd78: r = '{OP_MUL, R_T, R_MA, R_A0, L_NONE};
      7'd79: r = '{OP_SUB, R_BA, R_A1, R_T, L_NONE};
      7'd80: r = '{OP_SUB, R_T, R_C0, R_C2, L_NONE};
      7'd81: r = '{OP_BZ, R_T, R_T, R_T, L_FAIL};
      7'd82: r = '{OP_SUB, R_T2, R_C1, R_C3, L_NONE};
      7'd83: r = '{OP_DIV, R_C2, R_T2, R_T, L_NONE};
      7'd84: r = '{OP_MUL, R_T, R_C2, R_C0, L_NONE};
      7'd85: r = '{OP_SUB, R_C3, R_C1, R_T, L_NONE};
      7'd86: r = '{OP_SUB, R_T, R_C2, R_MA, L_NONE};
      7'd87: r = '{OP_BZ, R_T, R_T, R_T, L_FAIL};
      7'd88: r = '{OP_SUB, R_T2, R_BA, R_C3, L_NONE};
      7'd89: r = '{OP_DIV, R_X, R_T2, R_T, L_NONE};
      7'd90: r = '{OP_MUL, R_T, R_MA, R_X, L_NONE};
      7'd91: r = '{OP_ADD, R_T2, R_T, R_BA, L_NONE};
      7'd92: r = '{OP_EMIT, R_T, R_X, R_T2, L_NONE};
      7'd93: r = '{OP_FAIL, R_T, R_X, R_T2, L_NONE};
      default: r = '{OP_JMP, R_T, R_T, R_T, L_NONE};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/qcep_arith.sv =====
`default_nettype none
module qcep_arith (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire qcep_pkg::arith_req_t req,
  input  wire logic [47:0]         a,
  input  wire logic [47:0]         b,
  output logic                     done,
  output logic [47:0]              result
);

  logic        busy;
  logic [6:0]  cnt;
  logic [1:0]  mode;
  logic        neg;
  logic [47:0] dv;
  logic [47:0] hi;
  logic [71:0] lo;

  logic [47:0] na, nb;
  logic [48:0] msum;
  logic [48:0] r2;
  logic        ge;
  logic [95:0] prod;
  logic [71:0] mag, lim, clip;

  always_comb begin
    na = a[47] ? 48'(-a) : a;
    nb = b[47] ? 48'(-b) : b;
    msum = lo[0] ? ({1'b0, hi} + {1'b0, dv}) : {1'b0, hi};
    r2 = {hi, lo[71]};
    ge = r2 >= {1'b0, dv};
    prod = {hi, lo[47:0]};
    mag = (mode == qcep_pkg::AM_MUL) ? prod[95:24] : lo;
    lim = neg ? (72'd1 << 47) : ((72'd1 << 47) - 72'd1);
    clip = (mag > lim) ? lim : mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        mode <= req.mode;
        neg <= a[47] ^ b[47];
        hi <= '0;
        if (req.mode == qcep_pkg::AM_MUL) begin
          dv <= na;
          lo <= {24'b0, nb};
          cnt <= 7'd48;
        end else begin
          dv <= nb;
          lo <= (req.mode == qcep_pkg::AM_QDIV) ? {na, 24'b0} : {24'b0, na};
          cnt <= 7'd72;
        end
      end else if (busy) begin
        if (cnt != 7'd0) begin
          cnt <= cnt - 7'd1;
          if (mode == qcep_pkg::AM_MUL) begin
            hi <= msum[48:1];
            lo <= {24'b0, msum[0], lo[47:1]};
          end else begin
            hi <= ge ? 48'(r2 - {1'b0, dv}) : r2[47:0];
            lo <= {lo[70:0], ge};
          end
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
          result <= neg ? 48'(-clip[47:0]) : clip[47:0];
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/quadratic_curve_envelope_points_unit.sv =====
// throughput: one request at a time; s_tready stays low until the last point is loaded out
// the shared arithmetic unit holds the sequencer in its wait state during a multiply or a divide;
// other sequencer instructions pass through register file read, then execute
// reset (rst, synchronous): sequencer idle, output empty, segments back to 16
`default_nettype none
module quadratic_curve_envelope_points_unit #(
  parameter int MAX_SEGMENTS = qcep_pkg::MAX_SEGMENTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // start_x, start_y, end_x, end_y, ctrl_x, ctrl_y
  input  wire logic [95:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // point_x, point_y
  output logic [31:0]      m_tdata,
  // point_ok
  output logic             m_tuser,
  output logic             m_tlast
);

  localparam int NW = $clog2(MAX_SEGMENTS + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_WAIT  = 2'd3;

  logic [1:0]  state;
  logic [6:0]  segments;
  logic [95:0] in_data;
  logic [NW-1:0] n, idx;
  logic [6:0]  pc;
  qcep_pkg::ins_t ins, fins;
  logic [47:0] rda, rdb;
  logic [47:0] rf [0:31];

  logic        rf_we;
  logic [47:0] rf_wd;
  logic [15:0] fld;
  logic [48:0] sum, dif;
  logic        out_free;
  logic        out_load;
  qcep_pkg::arith_req_t areq;
  logic [47:0] arg_b;
  logic        a_done;
  logic [47:0] a_res;
  logic [NW-1:0] n_in;

  function automatic logic [47:0] sat48(input logic [48:0] v);
    if (v[48] != v[47]) return v[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    return v[47:0];
  endfunction

  function automatic logic [15:0] to_int16(input logic [47:0] q);
    logic [47:0] m;
    logic [23:0] ip;
    m = q[47] ? 48'(-q) : q;
    ip = m[47:24];
    if (q[47]) return (ip > 24'd32768) ? 16'h8000 : 16'(-ip);
    return (ip > 24'd32767) ? 16'h7fff : ip[15:0];
  endfunction

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign out_load = (state == S_EXEC) && out_free &&
                    (ins.op == qcep_pkg::OP_EMIT || ins.op == qcep_pkg::OP_FAIL);
  assign fins = qcep_pkg::rom(pc);
  assign n_in = (32'(segments) > MAX_SEGMENTS) ? NW'(MAX_SEGMENTS) : NW'(segments);

  always_comb begin
    case (ins.a[2:0])
      3'd0: fld = in_data[15:0];
      3'd1: fld = in_data[31:16];
      3'd2: fld = in_data[47:32];
      3'd3: fld = in_data[63:48];
      3'd4: fld = in_data[79:64];
      default: fld = in_data[95:80];
    endcase
    sum = {rda[47], rda} + {rdb[47], rdb};
    dif = {rda[47], rda} - {rdb[47], rdb};
    rf_we = 1'b0;
    rf_wd = a_res;
    areq = '{start: 1'b0, mode: qcep_pkg::AM_MUL};
    arg_b = rdb;
    if (state == S_WAIT) begin
      rf_we = a_done;
    end else if (state == S_EXEC) begin
      case (ins.op)
        qcep_pkg::OP_LDI: begin
          rf_we = 1'b1;
          rf_wd = {{8{fld[15]}}, fld, 24'b0};
        end
        qcep_pkg::OP_MOV: begin
          rf_we = 1'b1;
          rf_wd = rda;
        end
        qcep_pkg::OP_ADD: begin
          rf_we = 1'b1;
          rf_wd = sat48(sum);
        end
        qcep_pkg::OP_SUB: begin
          rf_we = 1'b1;
          rf_wd = sat48(dif);
        end
        qcep_pkg::OP_MUL: areq = '{start: 1'b1, mode: qcep_pkg::AM_MUL};
        qcep_pkg::OP_DIV: areq = '{start: 1'b1, mode: qcep_pkg::AM_QDIV};
        qcep_pkg::OP_IDIV: begin
          areq = '{start: 1'b1, mode: qcep_pkg::AM_IDIV};
          arg_b = 48'(n) + 48'd1;
        end
        default: rf_we = 1'b0;
      endcase
    end
  end

  qcep_arith u_arith (
    .clk    (clk),
    .rst    (rst),
    .req    (areq),
    .a      (rda),
    .b      (arg_b),
    .done   (a_done),
    .result (a_res)
  );

  always_ff @(posedge clk) begin
    if (state == S_FETCH) begin
      ins <= fins;
      rda <= rf[fins.a];
      rdb <= rf[fins.b];
    end
    if (rf_we) rf[ins.d] <= rf_wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      segments <= 7'd16;
      m_tvalid <= 1'b0;
      pc <= '0;
      idx <= '0;
      n <= '0;
    end else begin
      if (cfg_we) segments <= cfg_wdata;
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            in_data <= s_tdata;
            n <= n_in;
            idx <= '0;
            pc <= '0;
            if (n_in != '0) state <= S_FETCH;
          end
        end
        S_FETCH: state <= S_EXEC;
        S_WAIT: begin
          if (a_done) begin
            pc <= pc + 7'd1;
            state <= S_FETCH;
          end
        end
        default: begin
          case (ins.op)
            qcep_pkg::OP_MUL, qcep_pkg::OP_DIV, qcep_pkg::OP_IDIV: state <= S_WAIT;
            qcep_pkg::OP_BZ: begin
              pc <= (rda == '0) ? ins.tgt : pc + 7'd1;
              state <= S_FETCH;
            end
            qcep_pkg::OP_BNZ: begin
              pc <= (rda != '0) ? ins.tgt : pc + 7'd1;
              state <= S_FETCH;
            end
            qcep_pkg::OP_JMP: begin
              pc <= ins.tgt;
              state <= S_FETCH;
            end
            qcep_pkg::OP_EMIT, qcep_pkg::OP_FAIL: begin
              if (out_free) begin
                m_tuser <= (ins.op == qcep_pkg::OP_EMIT);
                m_tdata <= (ins.op == qcep_pkg::OP_EMIT) ? {to_int16(rdb), to_int16(rda)}
                                                          : 32'b0;
                m_tlast <= (idx == n - NW'(1));
                if (idx == n - NW'(1)) begin
                  state <= S_IDLE;
                end else begin
                  idx <= idx + NW'(1);
                  pc <= qcep_pkg::L_LOOP;
                  state <= S_FETCH;
                end
              end
            end
            default: begin
              pc <= pc + 7'd1;
              state <= S_FETCH;
            end
          endcase
        end
      endcase
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    a_done |-> state == S_WAIT)
    else $error("arithmetic result with no instruction waiting");

  out_load_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_EXEC)
    else $error("output loaded outside an emit instruction");

  fail_point_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 32'b0)
    else $error("failed point carries nonzero data");

endmodule
`default_nettype wire
